@@ sv/magic_sync_frame_deframer_unit_macros.svh @@
// assertion macros for the sync frame deframer
`ifndef MAGIC_SYNC_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define MAGIC_SYNC_FRAME_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MSFD_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MSFD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/msfd_pkg.sv @@
package msfd_pkg;

    localparam int SYNC_LEN         = 2;
    localparam int FULL_HDR_CONTROL = 5;
    localparam int FULL_HDR_DATA    = 7;
    localparam int STORE_DEPTH      = FULL_HDR_DATA - SYNC_LEN;
    localparam int FILL_W           = $clog2(STORE_DEPTH + 1);

    localparam logic [FILL_W-1:0] HDR_CONTROL = FILL_W'(FULL_HDR_CONTROL - SYNC_LEN);
    localparam logic [FILL_W-1:0] HDR_DATA    = FILL_W'(FULL_HDR_DATA - SYNC_LEN);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_IS_DATA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONTROL_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA_LENGTH    = 3'd4;

    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_FIRST   = 2'd1,
        PH_HEADER  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef logic [STORE_DEPTH-1:0][7:0] store_t;

    typedef struct packed {
        phase_t              phase;
        logic [FILL_W-1:0]   fill;
        store_t              store;
    } hunt_t;

    // one byte through the sync hunt and plain header collection
    function automatic hunt_t hunt_step(hunt_t h, logic [7:0] b,
                                        logic [7:0] mf, logic [7:0] ms);
        hunt_t r;
        r = h;
        case (h.phase)
            PH_HUNT: begin
                if (b == mf) r.phase = PH_FIRST;
            end
            PH_FIRST: begin
                if (b == ms) begin
                    r.phase = PH_HEADER;
                    r.fill  = '0;
                end else if (b == mf) begin
                    r.phase = PH_FIRST;
                end else begin
                    r.phase = PH_HUNT;
                end
            end
            PH_HEADER: begin
                if (h.fill < FILL_W'(STORE_DEPTH)) begin
                    r.store[h.fill] = b;
                    r.fill = h.fill + FILL_W'(1);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

endpackage

@@ sv/magic_sync_frame_deframer_unit.sv @@
// path: an accepted input beat is held in the input register, then its result beat in the result register on m_
// throughput: one byte per cycle while m_tready does not stall the result register, set by
//   the single-pass compare/count logic between the input register and the result register
// reset: aresetn synchronous active low; parser returns to sync hunt, registers
//   take 0, 0, 0, 65535, 4294967295, both stages empty
`include "magic_sync_frame_deframer_unit_macros.svh"

module magic_sync_frame_deframer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [msfd_pkg::OUT_DATA_W-1:0]  m_tdata,   // frame_type, frame_length, payload_byte
    output logic                             m_tuser,   // byte_valid
    output logic                             m_tlast,   // last_in_frame
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [msfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import msfd_pkg::*;

    logic        channel_is_data_reg;
    logic [7:0]  magic_first_reg;
    logic [7:0]  magic_second_reg;
    logic [15:0] max_control_length_reg;
    logic [31:0] max_data_length_reg;

    phase_t            phase_reg, phase_next;
    store_t            store_reg, store_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        held_type_reg, held_type_next;
    logic [31:0]       held_length_reg, held_length_next;
    logic [31:0]       bytes_left_reg, bytes_left_next;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;
    logic                  out_last_reg;

    logic advance, proc, cfg_we;

    hunt_t             cur, h1, rescan;
    logic [FILL_W-1:0] hdr_size;
    logic              hdr_done;
    logic [31:0]       hdr_len, hdr_limit;
    logic              hdr_over;

    logic        res_valid;
    logic [7:0]  res_type;
    logic [31:0] res_len;
    logic [7:0]  res_byte;
    logic        res_bvalid;
    logic        res_last;

    assign advance   = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // header decode shared by next-state and output logic
    always_comb begin
        cur.phase = phase_reg;
        cur.fill  = fill_reg;
        cur.store = store_reg;
        hdr_size  = channel_is_data_reg ? HDR_DATA : HDR_CONTROL;
        h1        = hunt_step(cur, in_data_reg, magic_first_reg, magic_second_reg);
        hdr_done  = (h1.fill >= hdr_size);
        if (channel_is_data_reg) begin
            hdr_len   = {h1.store[1], h1.store[2], h1.store[3], h1.store[4]};
            hdr_limit = max_data_length_reg;
        end else begin
            hdr_len   = {16'd0, h1.store[1], h1.store[2]};
            hdr_limit = {16'd0, max_control_length_reg};
        end
        hdr_over = (hdr_len > hdr_limit);
        // oversized header: drop sync word, hunt again through stored bytes
        rescan.phase = PH_HUNT;
        rescan.fill  = '0;
        rescan.store = h1.store;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (FILL_W'(i) < hdr_size) begin
                rescan = hunt_step(rescan, h1.store[i], magic_first_reg, magic_second_reg);
            end
        end
    end

    // next state
    always_comb begin
        phase_next       = phase_reg;
        store_next       = store_reg;
        fill_next        = fill_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        bytes_left_next  = bytes_left_reg;
        if (proc) begin
            case (phase_reg)
                PH_PAYLOAD: begin
                    if (bytes_left_reg <= 32'd1) begin
                        bytes_left_next = '0;
                        phase_next      = PH_HUNT;
                    end else begin
                        bytes_left_next = bytes_left_reg - 32'd1;
                    end
                end
                PH_HEADER: begin
                    if (!hdr_done) begin
                        phase_next = h1.phase;
                        fill_next  = h1.fill;
                        store_next = h1.store;
                    end else if (hdr_over) begin
                        phase_next = rescan.phase;
                        fill_next  = rescan.fill;
                        store_next = rescan.store;
                    end else begin
                        store_next       = h1.store;
                        held_type_next   = h1.store[0];
                        held_length_next = hdr_len;
                        fill_next        = '0;
                        if (hdr_len == 32'd0) begin
                            phase_next = PH_HUNT;
                        end else begin
                            bytes_left_next = hdr_len;
                            phase_next      = PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    phase_next = h1.phase;
                    fill_next  = h1.fill;
                    store_next = h1.store;
                end
            endcase
        end
        if (cfg_we && cfg_index == CFG_CHANNEL_IS_DATA) begin
            phase_next      = PH_HUNT;
            fill_next       = '0;
            bytes_left_next = '0;
        end
    end

    // result of the byte in the input register
    always_comb begin
        res_valid  = 1'b0;
        res_type   = held_type_reg;
        res_len    = held_length_reg;
        res_byte   = in_data_reg;
        res_bvalid = 1'b1;
        res_last   = 1'b0;
        case (phase_reg)
            PH_PAYLOAD: begin
                res_valid = 1'b1;
                res_last  = (bytes_left_reg <= 32'd1);
            end
            PH_HEADER: begin
                if (hdr_done && !hdr_over && hdr_len == 32'd0) begin
                    res_valid  = 1'b1;
                    res_type   = h1.store[0];
                    res_len    = hdr_len;
                    res_byte   = '0;
                    res_bvalid = 1'b0;
                    res_last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_is_data_reg    <= 1'b0;
            magic_first_reg        <= '0;
            magic_second_reg       <= '0;
            max_control_length_reg <= 16'hFFFF;
            max_data_length_reg    <= 32'hFFFF_FFFF;
            phase_reg              <= PH_HUNT;
            store_reg              <= '0;
            fill_reg               <= '0;
            held_type_reg          <= '0;
            held_length_reg        <= '0;
            bytes_left_reg         <= '0;
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            store_reg       <= store_next;
            fill_reg        <= fill_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            bytes_left_reg  <= bytes_left_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CHANNEL_IS_DATA:    channel_is_data_reg    <= cfg_data[0];
                    CFG_MAGIC_FIRST:        magic_first_reg        <= cfg_data[7:0];
                    CFG_MAGIC_SECOND:       magic_second_reg       <= cfg_data[7:0];
                    CFG_MAX_CONTROL_LENGTH: max_control_length_reg <= cfg_data[15:0];
                    CFG_MAX_DATA_LENGTH:    max_data_length_reg    <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= proc && res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (proc && res_valid) begin
            out_data_reg <= {res_byte, res_len, res_type};
            out_user_reg <= res_bvalid;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    `MSFD_ASSERT_IMPLY(a_empty_is_last, m_tvalid && !m_tuser, m_tlast, "empty notice not last")
    `MSFD_ASSERT_IMPLY(a_payload_count, phase_reg == PH_PAYLOAD, bytes_left_reg != 32'd0,
        "payload phase with no bytes left")
    `MSFD_ASSERT_IMPLY(a_fill_bound, phase_reg == PH_HEADER, fill_reg < hdr_size,
        "header fill reached header size")
    `MSFD_ASSERT_NEXT(a_result_loaded, proc && res_valid, out_valid_reg, "result lost")

endmodule

@@ test/magic_sync_frame_deframer_unit_tb.sv @@
module magic_sync_frame_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msfd_pkg::*;

    localparam int GAP_PCT        = 8;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PAYLOAD    = 24;

    typedef struct {
        logic [7:0]  ftype;
        logic [31:0] flen;
        logic [7:0]  pbyte;
        logic        valid;
        logic        last;
    } frame_beat_t;

    class frame_scoreboard;
        bit          is_data;
        logic [7:0]  sync_a;
        logic [7:0]  sync_b;
        logic [15:0] ctl_limit;
        logic [31:0] data_limit;
        phase_t      phase;
        logic [7:0]  hdr_bytes [STORE_DEPTH];
        int          hdr_count;
        logic [7:0]  cur_type;
        logic [31:0] cur_len;
        logic [31:0] remaining;
        frame_beat_t expected_q [$];
        int          errors;
        int          beats_checked;
        int          frames_closed;
        int          empty_frames;
        int          rejected_headers;

        function new();
            is_data = 1'b0;
            sync_a = 8'h00;
            sync_b = 8'h00;
            ctl_limit = 16'hFFFF;
            data_limit = 32'hFFFF_FFFF;
            phase = PH_HUNT;
            foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
            hdr_count = 0;
            cur_type = 8'h00;
            cur_len = 32'h0;
            remaining = 32'h0;
            errors = 0;
            beats_checked = 0;
            frames_closed = 0;
            empty_frames = 0;
            rejected_headers = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CHANNEL_IS_DATA: begin
                    is_data = data[0];
                    phase = PH_HUNT;
                    hdr_count = 0;
                    remaining = 32'h0;
                end
                CFG_MAGIC_FIRST: sync_a = data[7:0];
                CFG_MAGIC_SECOND: sync_b = data[7:0];
                CFG_MAX_CONTROL_LENGTH: ctl_limit = data[15:0];
                CFG_MAX_DATA_LENGTH: data_limit = data;
                default: ;
            endcase
        endfunction

        function void sync_scan(logic [7:0] b);
            case (phase)
                PH_HUNT: begin
                    if (b == sync_a) phase = PH_FIRST;
                end
                PH_FIRST: begin
                    if (b == sync_b) begin
                        phase = PH_HEADER;
                        hdr_count = 0;
                    end else if (b != sync_a) begin
                        phase = PH_HUNT;
                    end
                end
                PH_HEADER: begin
                    if (hdr_count < STORE_DEPTH) begin
                        hdr_bytes[hdr_count] = b;
                        hdr_count++;
                    end
                end
                default: ;
            endcase
        endfunction

        function void push_beat(logic [7:0] b, logic valid, logic last);
            frame_beat_t beat;
            beat.ftype = cur_type;
            beat.flen = cur_len;
            beat.pbyte = b;
            beat.valid = valid;
            beat.last = last;
            expected_q.insert(expected_q.size(), beat);
            if (last) frames_closed++;
            if (!valid) empty_frames++;
        endfunction

        function void note_byte(logic [7:0] b);
            int          need;
            logic [31:0] len;
            logic [31:0] limit;
            logic [7:0]  saved [STORE_DEPTH];
            logic        last;
            if (phase == PH_PAYLOAD) begin
                last = (remaining <= 32'd1);
                push_beat(b, 1'b1, last);
                if (last) begin
                    remaining = 32'h0;
                    phase = PH_HUNT;
                end else begin
                    remaining--;
                end
                return;
            end
            if (phase != PH_HEADER) begin
                sync_scan(b);
                return;
            end
            need = is_data ? int'(HDR_DATA) : int'(HDR_CONTROL);
            sync_scan(b);
            if (hdr_count < need) return;
            if (is_data) begin
                len = {hdr_bytes[1], hdr_bytes[2], hdr_bytes[3], hdr_bytes[4]};
                limit = data_limit;
            end else begin
                len = {16'h0, hdr_bytes[1], hdr_bytes[2]};
                limit = {16'h0, ctl_limit};
            end
            if (len > limit) begin
                // drop the sync word and hunt again through the header bytes
                rejected_headers++;
                saved = hdr_bytes;
                phase = PH_HUNT;
                hdr_count = 0;
                for (int i = 0; i < need; i++) sync_scan(saved[i]);
                return;
            end
            cur_type = hdr_bytes[0];
            cur_len = len;
            hdr_count = 0;
            if (len == 32'h0) begin
                push_beat(8'h00, 1'b0, 1'b1);
                phase = PH_HUNT;
                return;
            end
            remaining = len;
            phase = PH_PAYLOAD;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_beat(frame_beat_t got);
            frame_beat_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: expected none actual type %h len %h byte %h valid %b last %b",
                         $time, got.ftype, got.flen, got.pbyte, got.valid, got.last);
                return;
            end
            want = expected_q.pop_front();
            beats_checked++;
            compare_field("frame_type", 32'(want.ftype), 32'(got.ftype));
            compare_field("frame_length", want.flen, got.flen);
            compare_field("payload_byte", 32'(want.pbyte), 32'(got.pbyte));
            compare_field("byte_valid", 32'(want.valid), 32'(got.valid));
            compare_field("last_in_frame", 32'(want.last), 32'(got.last));
        endfunction

        function void close_out();
            if (expected_q.size() != 0) begin
                errors++;
                $display("%0t missing beats: expected %0d more actual 0", $time, expected_q.size());
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_scoreboard board = new();

    bit          no_gaps = 1'b0;
    int          bytes_sent = 0;
    int          quiet = 0;
    bit          mode_data;
    logic [7:0]  sync1;
    logic [7:0]  sync2;
    logic [15:0] limit_ctl;
    logic [31:0] limit_dat;

    magic_sync_frame_deframer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end

    always @(posedge aclk) begin
        frame_beat_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) board.note_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got.ftype = m_tdata[7:0];
                got.flen = m_tdata[39:8];
                got.pbyte = m_tdata[47:40];
                got.valid = m_tuser;
                got.last = m_tlast;
                board.check_beat(got);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no beat for %0d cycles", $time, quiet);
                $display("magic_sync_frame_deframer_unit verification failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // unused upper bits of each register carry random junk
    task automatic set_regs(input bit d, input logic [7:0] a, input logic [7:0] b,
                            input logic [15:0] c, input logic [31:0] lim);
        mode_data = d;
        sync1 = a;
        sync2 = b;
        limit_ctl = c;
        limit_dat = lim;
        write_reg(CFG_MAGIC_FIRST, ($urandom & 32'hFFFF_FF00) | 32'(a));
        write_reg(CFG_MAGIC_SECOND, ($urandom & 32'hFFFF_FF00) | 32'(b));
        write_reg(CFG_MAX_CONTROL_LENGTH, ($urandom & 32'hFFFF_0000) | 32'(c));
        write_reg(CFG_MAX_DATA_LENGTH, lim);
        write_reg(CFG_MAX_DATA_LENGTH + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
        write_reg(CFG_CHANNEL_IS_DATA, ($urandom & 32'hFFFF_FFFE) | 32'(d));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_head(input logic [31:0] len);
        send_byte(sync1);
        send_byte(sync2);
        send_byte(8'($urandom));
        if (mode_data) begin
            send_byte(len[31:24]);
            send_byte(len[23:16]);
        end
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_frame(input bit oversized);
        longint unsigned top;
        longint unsigned lim;
        longint unsigned len;
        top = mode_data ? 64'hFFFF_FFFF : 64'hFFFF;
        lim = mode_data ? 64'(limit_dat) : 64'(limit_ctl);
        if (oversized && lim < top) begin
            len = lim + 1 + ($urandom % (top - lim));
        end else begin
            len = 64'($urandom_range(0, 32'(lim < MAX_PAYLOAD ? lim : MAX_PAYLOAD)));
        end
        send_head(32'(len));
        if (len <= lim) begin
            for (int i = 0; i < int'(len); i++) send_byte(8'($urandom));
        end
    endtask

    task automatic send_noise(input bit safe);
        logic [7:0] b;
        repeat ($urandom_range(1, 4)) begin
            do b = 8'($urandom); while (safe && b == sync1);
            send_byte(b);
        end
    endtask

    // sync word cut short: either a truncated header or a false start
    task automatic send_broken(input bit risky);
        logic [7:0] b;
        int         need;
        need = mode_data ? int'(HDR_DATA) : int'(HDR_CONTROL);
        if (risky) begin
            send_byte(sync1);
            send_byte(sync2);
            repeat ($urandom_range(0, need - 1)) send_byte(8'($urandom));
        end else begin
            send_byte(sync1);
            if ($urandom_range(0, 1)) send_byte(sync1);
            do b = 8'($urandom); while (b == sync1 || b == sync2);
            send_byte(b);
        end
    endtask

    task automatic run_phase(input int n_bytes, input bit risky);
        int start;
        int r;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_frame(risky && $urandom_range(0, 4) == 0);
            end else if (r < 85) begin
                send_noise(!risky);
            end else begin
                send_broken(risky);
            end
        end
    endtask

    initial begin
        logic [7:0] seq [$];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = CFG_CHANNEL_IS_DATA;
        cfg_data = '0;
        mode_data = 1'b0;
        sync1 = 8'h00;
        sync2 = 8'h00;
        limit_ctl = 16'hFFFF;
        limit_dat = 32'hFFFF_FFFF;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: equal zero sync bytes, empty control frame
        seq = '{8'h00, 8'h00, 8'h07, 8'h00, 8'h00};
        foreach (seq[i]) send_byte(seq[i]);
        wait_idle();

        set_regs(1'b0, 8'hA5, 8'h5A, 16'd4, 32'hFFFF_FFFF);
        seq = '{8'hA5, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF,
                8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'h07, 8'h00, 8'h01, 8'h80,
                8'hA5, 8'h5A, 8'h00, 8'h00, 8'hA5, 8'h5A, 8'h03, 8'h00, 8'h00};
        foreach (seq[i]) send_byte(seq[i]);
        wait_idle();

        set_regs(1'b0, 8'hA5, 8'h5A, 16'd20, 32'hFFFF_FFFF);
        run_phase(200, 1'b1);
        wait_idle();

        set_regs(1'b1, 8'h3C, 8'h3C, 16'd0, 32'd30);
        run_phase(200, 1'b1);
        wait_idle();

        // frame cut off by a mode write
        write_reg(CFG_CHANNEL_IS_DATA, 32'(1'b1));
        cfg_valid <= 1'b0;
        send_head(32'd10);
        repeat (3) send_byte(8'($urandom));
        wait_idle();

        no_gaps = 1'b1;
        set_regs(1'b1, 8'h00, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_phase(150, 1'b0);
        wait_idle();
        no_gaps = 1'b0;

        set_regs(1'b0, 8'hFF, 8'h00, 16'hFFFF, 32'd0);
        run_phase(150, 1'b0);
        wait_idle();

        set_regs(1'b0, 8'($urandom), 8'($urandom), 16'd0, 32'($urandom));
        run_phase(120, 1'b1);
        wait_idle();

        set_regs(1'b1, 8'($urandom), 8'($urandom), 16'($urandom), 32'd0);
        run_phase(120, 1'b1);
        wait_idle();

        board.close_out();
        $display("%0d bytes in, %0d result beats checked, %0d frames closed, %0d empty, %0d headers rejected",
                 bytes_sent, board.beats_checked, board.frames_closed, board.empty_frames,
                 board.rejected_headers);
        $display("both modes, equal and distinct sync bytes, length limits at the extremes, mode switch mid-frame");
        if (board.errors == 0) begin
            $display("magic_sync_frame_deframer_unit verification clean");
        end else begin
            $display("magic_sync_frame_deframer_unit verification failed");
        end
        $finish;
    end

endmodule

@@ magic_sync_frame_deframer_unit.f @@
+incdir+sv
sv/msfd_pkg.sv
sv/magic_sync_frame_deframer_unit.sv
test/magic_sync_frame_deframer_unit_tb.sv
